// ===== rtl/tcd_pkg.sv =====
// ============================================================================
// Timer and cooldown table package
// Shared opcodes, command classes, table entry layouts and divider ports.
// ============================================================================
package tcd_pkg;

   // Field widths
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 24;
   localparam int REM_W    = 26;
   localparam int LEFT_W   = 16;
   localparam int DT_W     = 16;
   localparam int FIRE_W   = 8;
   localparam int OVER_W   = 16;

   // Depth of the queue between the front and the engine.
   localparam int QUEUE_DEPTH = 2;

   // Opcodes as they arrive on the request channel.
   localparam logic [3:0] OP_TICK      = 4'd0;
   localparam logic [3:0] OP_ADD_TIMER = 4'd1;
   localparam logic [3:0] OP_CANCEL    = 4'd2;
   localparam logic [3:0] OP_ADD_CD    = 4'd3;
   localparam logic [3:0] OP_READY     = 4'd4;
   localparam logic [3:0] OP_CONSUME   = 4'd5;
   localparam logic [3:0] OP_RESET_CD  = 4'd6;
   localparam logic [3:0] OP_FREE_CD   = 4'd7;
   localparam logic [3:0] OP_CLEAR_CD  = 4'd8;
   localparam logic [3:0] OP_CLEAR_ALL = 4'd9;

   // Result kinds.
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   typedef enum logic [3:0] {
      CMD_TICK,
      CMD_ADD_TIMER,
      CMD_CANCEL,
      CMD_ADD_CD,
      CMD_READY,
      CMD_CONSUME,
      CMD_RESET_CD,
      CMD_FREE_CD,
      CMD_CLEAR_CD,
      CMD_CLEAR_ALL,
      CMD_UNKNOWN
   } cmd_class_type;

   // A classified command as it waits in the queue.
   typedef struct packed {
      cmd_class_type       cls;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic                repeat_mode;
      logic                limit_enable;
      logic [LEFT_W-1:0]   limit_count;
      logic                notify_enable;
      logic [DT_W-1:0]     elapsed;
   } cmd_type;

   typedef struct packed {
      logic signed [REM_W-1:0] remaining;
      logic [PERIOD_W-1:0]     interval;
      logic                    repeats;
      logic                    limited;
      logic [LEFT_W-1:0]       left;
      logic                    notify;
   } timer_entry_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]     length;
      logic signed [REM_W-1:0] remaining;
   } cd_entry_type;

   typedef struct packed {
      logic                start;
      logic [OVER_W-1:0]   dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [OVER_W-1:0]   quot;
      logic [PERIOD_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== rtl/tcd_front.sv =====
// ============================================================================
// Timer and cooldown table front end
// Accepts requests, classifies the opcode, fixes a zero period to one and
// holds the commands in a short queue for the engine.
// ============================================================================
module tcd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_opcode,
   input  logic [tcd_pkg::SLOT_W-1:0]     req_slot,
   input  logic [tcd_pkg::PERIOD_W-1:0]   req_period_ms,
   input  logic                           req_repeat_mode,
   input  logic                           req_limit_enable,
   input  logic [tcd_pkg::LEFT_W-1:0]     req_limit_count,
   input  logic                           req_notify_enable,
   input  logic [tcd_pkg::DT_W-1:0]       req_elapsed_ms,
   output logic                           q_valid,
   output tcd_pkg::cmd_type               q_item,
   input  logic                           q_pop
);

   localparam int PTR_W = (tcd_pkg::QUEUE_DEPTH > 1) ? $clog2(tcd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tcd_pkg::QUEUE_DEPTH + 1);

   tcd_pkg::cmd_type   queue_ff [tcd_pkg::QUEUE_DEPTH];
   tcd_pkg::cmd_type   item;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   // Classify the incoming request.
   always_comb begin
      item.slot          = req_slot;
      item.period        = (req_period_ms == '0) ? tcd_pkg::PERIOD_W'(1) : req_period_ms;
      item.repeat_mode   = req_repeat_mode;
      item.limit_enable  = req_limit_enable;
      item.limit_count   = req_limit_count;
      item.notify_enable = req_notify_enable;
      item.elapsed       = req_elapsed_ms;
      case (req_opcode)
         tcd_pkg::OP_TICK:      item.cls = tcd_pkg::CMD_TICK;
         tcd_pkg::OP_ADD_TIMER: item.cls = tcd_pkg::CMD_ADD_TIMER;
         tcd_pkg::OP_CANCEL:    item.cls = tcd_pkg::CMD_CANCEL;
         tcd_pkg::OP_ADD_CD:    item.cls = tcd_pkg::CMD_ADD_CD;
         tcd_pkg::OP_READY:     item.cls = tcd_pkg::CMD_READY;
         tcd_pkg::OP_CONSUME:   item.cls = tcd_pkg::CMD_CONSUME;
         tcd_pkg::OP_RESET_CD:  item.cls = tcd_pkg::CMD_RESET_CD;
         tcd_pkg::OP_FREE_CD:   item.cls = tcd_pkg::CMD_FREE_CD;
         tcd_pkg::OP_CLEAR_CD:  item.cls = tcd_pkg::CMD_CLEAR_CD;
         tcd_pkg::OP_CLEAR_ALL: item.cls = tcd_pkg::CMD_CLEAR_ALL;
         default:               item.cls = tcd_pkg::CMD_UNKNOWN;
      endcase
   end

   assign req_ready = (count_ff != CNT_W'(tcd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = queue_ff[rd_ptr_ff];

   // Queue pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/tcd_div.sv =====
// ============================================================================
// Timer and cooldown table divider
// Restoring divider, one quotient bit per cycle, for the overrun of a
// repeating timer by its interval.
// ============================================================================
module tcd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tcd_pkg::div_req_type  div_req,
   output tcd_pkg::div_rsp_type  div_rsp
);

   localparam int CNT_W = $clog2(tcd_pkg::OVER_W + 1);

   logic [tcd_pkg::PERIOD_W-1:0] part_ff, part_in;
   logic [tcd_pkg::OVER_W-1:0]   dvd_ff, dvd_in;
   logic [tcd_pkg::PERIOD_W-1:0] dsr_ff;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [tcd_pkg::PERIOD_W:0]   trial;
   logic                         ge;

   // One restoring step.
   assign trial = {part_ff, dvd_ff[tcd_pkg::OVER_W-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_comb begin
      part_in = part_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         part_in = '0;
         dvd_in  = div_req.dividend;
         cnt_in  = CNT_W'(tcd_pkg::OVER_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         part_in = ge ? tcd_pkg::PERIOD_W'(trial - {1'b0, dsr_ff})
                      : trial[tcd_pkg::PERIOD_W-1:0];
         dvd_in  = {dvd_ff[tcd_pkg::OVER_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      dvd_ff  <= dvd_in;
      if (div_req.start) begin
         dsr_ff <= div_req.divisor;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = dvd_ff;
   assign div_rsp.rem  = part_ff;

endmodule

// ===== rtl/tcd_engine.sv =====
// ============================================================================
// Timer and cooldown table engine
// Holds the timer and cooldown tables, carries out one queued command at a
// time and drives the registered result channel.
// ============================================================================
module tcd_engine #(
   parameter int NUM_TIMERS    = 16,
   parameter int NUM_COOLDOWNS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  tcd_pkg::cmd_type                q_item,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic                            rsp_ok,
   output logic [tcd_pkg::SLOT_W-1:0]      rsp_slot_out,
   output logic [tcd_pkg::FIRE_W-1:0]      rsp_fire_count,
   output logic                            rsp_removed,
   output logic                            rsp_last
);

   localparam int TW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW    = (NUM_COOLDOWNS > 1) ? $clog2(NUM_COOLDOWNS) : 1;
   localparam int MAX_N = (NUM_TIMERS > NUM_COOLDOWNS) ? NUM_TIMERS : NUM_COOLDOWNS;
   localparam int IW    = $clog2(MAX_N + 1);
   localparam int RW    = tcd_pkg::REM_W;
   localparam int DUE_W = tcd_pkg::LEFT_W + 1;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_DISP  = 11'b000_0000_0010,
      S_ASCAN = 11'b000_0000_0100,
      S_CSCAN = 11'b000_0000_1000,
      S_CEX   = 11'b000_0001_0000,
      S_TCHK  = 11'b000_0010_0000,
      S_TSUB  = 11'b000_0100_0000,
      S_TDIV  = 11'b000_1000_0000,
      S_CDCHK = 11'b001_0000_0000,
      S_CDSUB = 11'b010_0000_0000,
      S_EMIT  = 11'b100_0000_0000
   } state_type;

   state_type                      state_ff, state_in;
   tcd_pkg::cmd_type               cmd_ff, cmd_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [NUM_TIMERS-1:0]          t_act_ff, t_act_in;
   logic [NUM_COOLDOWNS-1:0]       c_act_ff, c_act_in;

   // Staged result, moved to the output register when it is free.
   logic                           res_kind_ff, res_kind_in;
   logic                           res_ok_ff, res_ok_in;
   logic [tcd_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [tcd_pkg::FIRE_W-1:0]     res_fire_ff, res_fire_in;
   logic                           res_rem_ff, res_rem_in;
   logic                           res_last_ff, res_last_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff;
   logic                           rsp_ok_ff;
   logic [tcd_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [tcd_pkg::FIRE_W-1:0]     rsp_fire_ff;
   logic                           rsp_rem_ff;
   logic                           rsp_last_ff;
   logic                           can_emit;
   logic                           rsp_load;

   // Table memories.
   tcd_pkg::timer_entry_type       t_mem [NUM_TIMERS];
   tcd_pkg::cd_entry_type          c_mem [NUM_COOLDOWNS];
   tcd_pkg::timer_entry_type       t_rd_ff;
   tcd_pkg::cd_entry_type          c_rd_ff;
   tcd_pkg::timer_entry_type       t_wdata;
   tcd_pkg::cd_entry_type          c_wdata;
   logic                           t_we;
   logic                           c_we;
   logic [CW-1:0]                  c_waddr;
   logic [CW-1:0]                  c_raddr;

   logic [TW-1:0]                  t_idx;
   logic [CW-1:0]                  c_idx;
   logic [TW-1:0]                  t_slot;
   logic [CW-1:0]                  c_slot;
   logic                           t_in_range;
   logic                           c_ok;

   logic signed [RW-1:0]           dt_s;
   logic signed [RW-1:0]           rem_sub;
   logic signed [RW-1:0]           c_rem_sub;
   logic [RW-1:0]                  neg_rem;
   logic [DUE_W-1:0]               due;
   logic [DUE_W-1:0]               lim;
   logic                           lim_hit;
   logic [DUE_W-1:0]               fires;
   logic [tcd_pkg::FIRE_W-1:0]     fire_sat;
   logic signed [RW-1:0]           reload;

   tcd_pkg::div_req_type           div_req;
   tcd_pkg::div_rsp_type           div_rsp;

   tcd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Addressing.
   assign t_idx      = idx_ff[TW-1:0];
   assign c_idx      = idx_ff[CW-1:0];
   assign t_slot     = TW'(cmd_ff.slot);
   assign c_slot     = CW'(cmd_ff.slot);
   assign t_in_range = (9'(cmd_ff.slot) < 9'(NUM_TIMERS));
   assign c_ok       = (9'(cmd_ff.slot) < 9'(NUM_COOLDOWNS)) && c_act_ff[c_slot];
   assign c_raddr    = (cmd_ff.cls == tcd_pkg::CMD_TICK) ? c_idx : c_slot;

   // Tick arithmetic on the entry under the scan index.
   assign dt_s      = signed'(RW'(cmd_ff.elapsed));
   assign rem_sub   = t_rd_ff.remaining - dt_s;
   assign c_rem_sub = c_rd_ff.remaining - dt_s;
   assign neg_rem   = -rem_sub;

   // Expiry count and reload of a repeating timer after the divide.
   assign due      = DUE_W'(div_rsp.quot) + DUE_W'(1);
   assign lim      = (t_rd_ff.left == '0) ? DUE_W'(1) : DUE_W'(t_rd_ff.left);
   assign lim_hit  = t_rd_ff.limited && (due >= lim);
   assign fires    = lim_hit ? lim : due;
   assign fire_sat = (fires > DUE_W'(255)) ? '1 : fires[tcd_pkg::FIRE_W-1:0];
   assign reload   = signed'(RW'(t_rd_ff.interval - div_rsp.rem));

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == S_EMIT) && can_emit;

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      t_act_in     = t_act_ff;
      c_act_in     = c_act_ff;
      res_kind_in  = res_kind_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      res_fire_in  = res_fire_ff;
      res_rem_in   = res_rem_ff;
      res_last_in  = res_last_ff;
      q_pop        = 1'b0;
      t_we         = 1'b0;
      t_wdata      = t_rd_ff;
      c_we         = 1'b0;
      c_waddr      = c_raddr;
      c_wdata      = c_rd_ff;
      div_req.start    = 1'b0;
      div_req.dividend = neg_rem[tcd_pkg::OVER_W-1:0];
      div_req.divisor  = t_rd_ff.interval;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_item;
               idx_in   = '0;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            res_kind_in = tcd_pkg::KIND_REPLY;
            res_ok_in   = 1'b0;
            res_slot_in = cmd_ff.slot;
            res_fire_in = '0;
            res_rem_in  = 1'b0;
            res_last_in = 1'b1;
            state_in    = S_EMIT;
            case (cmd_ff.cls)
               tcd_pkg::CMD_TICK: begin
                  state_in = S_TCHK;
               end
               tcd_pkg::CMD_ADD_TIMER: begin
                  res_slot_in = '0;
                  state_in    = S_ASCAN;
               end
               tcd_pkg::CMD_ADD_CD: begin
                  res_slot_in = '0;
                  state_in    = S_CSCAN;
               end
               tcd_pkg::CMD_CANCEL: begin
                  if (t_in_range && t_act_ff[t_slot]) begin
                     t_act_in[t_slot] = 1'b0;
                     res_ok_in        = 1'b1;
                  end
               end
               tcd_pkg::CMD_READY, tcd_pkg::CMD_CONSUME, tcd_pkg::CMD_RESET_CD: begin
                  if (c_ok) begin
                     state_in = S_CEX;
                  end
               end
               tcd_pkg::CMD_FREE_CD: begin
                  if (c_ok) begin
                     c_act_in[c_slot] = 1'b0;
                     res_ok_in        = 1'b1;
                  end
               end
               tcd_pkg::CMD_CLEAR_CD: begin
                  c_act_in    = '0;
                  res_ok_in   = 1'b1;
                  res_slot_in = '0;
               end
               tcd_pkg::CMD_CLEAR_ALL: begin
                  t_act_in    = '0;
                  c_act_in    = '0;
                  res_ok_in   = 1'b1;
                  res_slot_in = '0;
               end
               default: begin
                  res_slot_in = '0;
               end
            endcase
         end

         // Lowest free timer slot, one slot per cycle.
         S_ASCAN: begin
            if (idx_ff == IW'(NUM_TIMERS)) begin
               state_in = S_EMIT;
            end else if (!t_act_ff[t_idx]) begin
               t_we              = 1'b1;
               t_wdata.remaining = signed'(RW'(cmd_ff.period));
               t_wdata.interval  = cmd_ff.period;
               t_wdata.repeats   = cmd_ff.repeat_mode;
               t_wdata.limited   = cmd_ff.limit_enable;
               t_wdata.left      = cmd_ff.limit_count;
               t_wdata.notify    = cmd_ff.notify_enable;
               t_act_in[t_idx]   = 1'b1;
               res_ok_in         = 1'b1;
               res_slot_in       = tcd_pkg::SLOT_W'(idx_ff);
               state_in          = S_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Lowest free cooldown slot; a new cooldown starts ready.
         S_CSCAN: begin
            if (idx_ff == IW'(NUM_COOLDOWNS)) begin
               state_in = S_EMIT;
            end else if (!c_act_ff[c_idx]) begin
               c_we              = 1'b1;
               c_waddr           = c_idx;
               c_wdata.length    = cmd_ff.period;
               c_wdata.remaining = '0;
               c_act_in[c_idx]   = 1'b1;
               res_ok_in         = 1'b1;
               res_slot_in       = tcd_pkg::SLOT_W'(idx_ff);
               state_in          = S_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Query, consume or reset with the cooldown entry read back.
         S_CEX: begin
            state_in = S_EMIT;
            case (cmd_ff.cls)
               tcd_pkg::CMD_READY: begin
                  res_ok_in = (c_rd_ff.remaining <= 0);
               end
               tcd_pkg::CMD_CONSUME: begin
                  if (c_rd_ff.remaining <= 0) begin
                     c_we              = 1'b1;
                     c_wdata.remaining = signed'(RW'(c_rd_ff.length));
                     res_ok_in         = 1'b1;
                  end
               end
               default: begin
                  c_we              = 1'b1;
                  c_wdata.remaining = signed'(RW'(c_rd_ff.length));
                  res_ok_in         = 1'b1;
               end
            endcase
         end

         // Tick, timer pass: skip idle slots, read active ones.
         S_TCHK: begin
            if (idx_ff == IW'(NUM_TIMERS)) begin
               idx_in   = '0;
               state_in = S_CDCHK;
            end else if (t_act_ff[t_idx]) begin
               state_in = S_TSUB;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_TSUB: begin
            res_kind_in = tcd_pkg::KIND_EVENT;
            res_ok_in   = 1'b1;
            res_slot_in = tcd_pkg::SLOT_W'(idx_ff);
            res_fire_in = '0;
            res_rem_in  = 1'b0;
            res_last_in = 1'b0;
            if (rem_sub > 0) begin
               t_we              = 1'b1;
               t_wdata.remaining = rem_sub;
               idx_in            = idx_ff + 1'b1;
               state_in          = S_TCHK;
            end else if (!t_rd_ff.notify) begin
               t_act_in[t_idx] = 1'b0;
               res_rem_in      = 1'b1;
               state_in        = S_EMIT;
            end else if (!t_rd_ff.repeats) begin
               t_act_in[t_idx] = 1'b0;
               res_fire_in     = tcd_pkg::FIRE_W'(1);
               res_rem_in      = 1'b1;
               state_in        = S_EMIT;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_TDIV;
            end
         end

         // Repeating timer: fires from the divide, then reload or removal.
         S_TDIV: begin
            if (div_rsp.done) begin
               res_fire_in = fire_sat;
               if (lim_hit) begin
                  t_act_in[t_idx] = 1'b0;
                  res_rem_in      = 1'b1;
               end else begin
                  t_we              = 1'b1;
                  t_wdata.remaining = reload;
                  if (t_rd_ff.limited) begin
                     t_wdata.left = tcd_pkg::LEFT_W'(lim - due);
                  end
               end
               state_in = S_EMIT;
            end
         end

         // Tick, cooldown pass: lower every cooldown still running.
         S_CDCHK: begin
            if (idx_ff == IW'(NUM_COOLDOWNS)) begin
               res_kind_in = tcd_pkg::KIND_REPLY;
               res_ok_in   = 1'b1;
               res_slot_in = '0;
               res_fire_in = '0;
               res_rem_in  = 1'b0;
               res_last_in = 1'b1;
               state_in    = S_EMIT;
            end else if (c_act_ff[c_idx]) begin
               state_in = S_CDSUB;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_CDSUB: begin
            if (c_rd_ff.remaining > 0) begin
               c_we              = 1'b1;
               c_waddr           = c_idx;
               c_wdata.remaining = c_rem_sub;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_CDCHK;
         end

         // Hand the staged result to the output register.
         S_EMIT: begin
            if (can_emit) begin
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TCHK;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         t_act_ff     <= '0;
         c_act_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_act_ff     <= t_act_in;
         c_act_ff     <= c_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command, scan index and staged result.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      res_kind_ff <= res_kind_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      res_fire_ff <= res_fire_in;
      res_rem_ff  <= res_rem_in;
      res_last_ff <= res_last_in;
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_ok_ff   <= res_ok_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_fire_ff <= res_fire_ff;
         rsp_rem_ff  <= res_rem_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   // Timer memory, registered read at the scan index.
   always_ff @(posedge clock) begin
      if (t_we) begin
         t_mem[t_idx] <= t_wdata;
      end
      t_rd_ff <= t_mem[t_idx];
   end

   // Cooldown memory, registered read.
   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[c_waddr] <= c_wdata;
      end
      c_rd_ff <= c_mem[c_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_fire_count = rsp_fire_ff;
   assign rsp_removed    = rsp_rem_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== rtl/timer_and_cooldown_table.sv =====
// ============================================================================
// Timer and cooldown table
// Millisecond timer slots and cooldown slots driven by commands and ticks.
// ============================================================================
// An add scans the active bits one slot per cycle for the lowest free
// slot. A tick walks every timer slot and then every cooldown slot; a
// repeating timer that expires waits for the serial divide, and each
// event is handed to the output register. A two-entry queue sits
// between request acceptance and the engine, and results leave through an
// output register, so both sides can stall independently.
module timer_and_cooldown_table #(
   parameter int NUM_TIMERS    = 16,
   parameter int NUM_COOLDOWNS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [3:0]                      req_opcode,
   input  logic [tcd_pkg::SLOT_W-1:0]      req_slot,
   input  logic [tcd_pkg::PERIOD_W-1:0]    req_period_ms,
   input  logic                            req_repeat_mode,
   input  logic                            req_limit_enable,
   input  logic [tcd_pkg::LEFT_W-1:0]      req_limit_count,
   input  logic                            req_notify_enable,
   input  logic [tcd_pkg::DT_W-1:0]        req_elapsed_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic                            rsp_ok,
   output logic [tcd_pkg::SLOT_W-1:0]      rsp_slot_out,
   output logic [tcd_pkg::FIRE_W-1:0]      rsp_fire_count,
   output logic                            rsp_removed,
   output logic                            rsp_last
);

   logic              q_valid;
   logic              q_pop;
   tcd_pkg::cmd_type  q_item;

   // Request acceptance and classification.
   tcd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_slot          (req_slot),
      .req_period_ms     (req_period_ms),
      .req_repeat_mode   (req_repeat_mode),
      .req_limit_enable  (req_limit_enable),
      .req_limit_count   (req_limit_count),
      .req_notify_enable (req_notify_enable),
      .req_elapsed_ms    (req_elapsed_ms),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // Table state and command execution.
   tcd_engine #(
      .NUM_TIMERS    (NUM_TIMERS),
      .NUM_COOLDOWNS (NUM_COOLDOWNS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_ok         (rsp_ok),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_fire_count (rsp_fire_count),
      .rsp_removed    (rsp_removed),
      .rsp_last       (rsp_last)
   );

endmodule
